### rtl/assert_macros.svh
// Assertion macros shared by the traffic light lamp controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLMC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lamp controller check failed");
`define TLMC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lamp controller check failed");
`else
`define TLMC_ASSERT(label, clk, rst, prop)
`define TLMC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/tlmc_pkg.sv
// Types, register map and command decode for the traffic light lamp controller.
package tlmc_pkg;

   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   localparam logic [1:0] REG_NIGHT_ENTER = 2'd0;
   localparam logic [1:0] REG_DAY_ENTER   = 2'd1;
   localparam logic [1:0] REG_BLINK_HALF  = 2'd2;

   localparam logic [11:0] NIGHT_ENTER_RESET = 12'd2000;
   localparam logic [11:0] DAY_ENTER_RESET   = 12'd1000;
   localparam logic [15:0] BLINK_HALF_RESET  = 16'd500;

   // lamp vector bit order: red, yellow, green
   localparam logic [2:0] LAMP_NONE   = 3'b000;
   localparam logic [2:0] LAMP_YELLOW = 3'b010;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_SET,
      CMD_CLR,
      CMD_BLK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   mask;
   } cmd_type;

   typedef struct packed {
      logic [11:0] night_enter_level;
      logic [11:0] day_enter_level;
      logic [15:0] blink_half_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [4:0]  func;
      logic [11:0] light_level;
      logic [2:0]  btn;
      logic        motion;
      logic [31:0] now_ms;
   } item_type;

   function automatic cmd_type cmd_decode(input logic [4:0] func);
      cmd_type c;
      c.kind = CMD_NONE;
      c.mask = LAMP_NONE;
      unique case (func)
         5'd1:  begin c.kind = CMD_SET; c.mask = 3'b001; end
         5'd2:  begin c.kind = CMD_SET; c.mask = 3'b010; end
         5'd3:  begin c.kind = CMD_SET; c.mask = 3'b100; end
         5'd4:  begin c.kind = CMD_CLR; c.mask = 3'b001; end
         5'd5:  begin c.kind = CMD_CLR; c.mask = 3'b010; end
         5'd6:  begin c.kind = CMD_CLR; c.mask = 3'b100; end
         5'd7:  begin c.kind = CMD_CLR; c.mask = 3'b111; end
         5'd8:  begin c.kind = CMD_BLK; c.mask = 3'b001; end
         5'd9:  begin c.kind = CMD_BLK; c.mask = 3'b010; end
         5'd10: begin c.kind = CMD_BLK; c.mask = 3'b100; end
         5'd11: begin c.kind = CMD_BLK; c.mask = 3'b111; end
         5'd12: begin c.kind = CMD_SET; c.mask = 3'b011; end
         5'd13: begin c.kind = CMD_SET; c.mask = 3'b101; end
         5'd14: begin c.kind = CMD_SET; c.mask = 3'b110; end
         5'd15: begin c.kind = CMD_SET; c.mask = 3'b111; end
         5'd16: begin c.kind = CMD_CLR; c.mask = 3'b011; end
         5'd17: begin c.kind = CMD_CLR; c.mask = 3'b101; end
         5'd18: begin c.kind = CMD_CLR; c.mask = 3'b110; end
         5'd19: begin c.kind = CMD_BLK; c.mask = 3'b011; end
         5'd20: begin c.kind = CMD_BLK; c.mask = 3'b101; end
         5'd21: begin c.kind = CMD_BLK; c.mask = 3'b110; end
         default: begin c.kind = CMD_NONE; c.mask = LAMP_NONE; end
      endcase
      return c;
   endfunction

endpackage

### rtl/tlmc_csr.sv
// Configuration register bank with APB-style access.
module tlmc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tlmc_pkg::ADDR_W-1:0]   paddr,
   input  logic [tlmc_pkg::DATA_W-1:0]   pwdata,
   output logic [tlmc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output tlmc_pkg::cfg_type             cfg
);

   tlmc_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tlmc_pkg::REG_NIGHT_ENTER: cfg_in.night_enter_level    = pwdata[11:0];
            tlmc_pkg::REG_DAY_ENTER:   cfg_in.day_enter_level      = pwdata[11:0];
            tlmc_pkg::REG_BLINK_HALF:  cfg_in.blink_half_period_ms = pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_enter_level    <= tlmc_pkg::NIGHT_ENTER_RESET;
         cfg_ff.day_enter_level      <= tlmc_pkg::DAY_ENTER_RESET;
         cfg_ff.blink_half_period_ms <= tlmc_pkg::BLINK_HALF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tlmc_pkg::REG_NIGHT_ENTER: prdata = {20'd0, cfg_ff.night_enter_level};
         tlmc_pkg::REG_DAY_ENTER:   prdata = {20'd0, cfg_ff.day_enter_level};
         tlmc_pkg::REG_BLINK_HALF:  prdata = {16'd0, cfg_ff.blink_half_period_ms};
         default:                   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/tlmc_core.sv
// Lamp state update and result register for one control pass per cycle while the result is not stalled.
`include "assert_macros.svh"
module tlmc_core (
   input  logic               clock,
   input  logic               reset,
   input  tlmc_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  tlmc_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_led_red,
   output logic               rsp_led_yellow,
   output logic               rsp_led_green,
   output logic               rsp_buzzer_on,
   output logic               rsp_leds_changed
);

   logic [2:0]  steady_ff, steady_in;
   logic [2:0]  blink_ff, blink_in;
   logic        phase_ff, phase_in;
   logic        night_ff, night_in;
   logic [31:0] last_toggle_ff, last_toggle_in;
   logic [2:0]  prev_btn_ff;
   logic [2:0]  last_levels_ff, last_levels_in;
   logic        reported_ff, reported_in;
   logic        rsp_valid_ff;
   logic [4:0]  rsp_data_ff, rsp_data_in;

   tlmc_pkg::cmd_type cmd;
   logic [31:0]       elapsed;
   logic [2:0]        press;
   logic [2:0]        levels;
   logic              buzz;
   logic              changed;
   logic              fire;

   assign item_take = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = item_valid & item_take;
   assign cmd       = tlmc_pkg::cmd_decode(item.func);
   assign elapsed   = item.now_ms - last_toggle_ff;
   assign press     = item.btn & ~prev_btn_ff;

   always_comb begin
      steady_in      = steady_ff;
      blink_in       = blink_ff;
      night_in       = night_ff;
      phase_in       = phase_ff;
      last_toggle_in = last_toggle_ff;

      unique case (cmd.kind)
         tlmc_pkg::CMD_SET: begin
            steady_in = cmd.mask;
            blink_in  = tlmc_pkg::LAMP_NONE;
         end
         tlmc_pkg::CMD_BLK: begin
            steady_in = tlmc_pkg::LAMP_NONE;
            blink_in  = cmd.mask;
         end
         tlmc_pkg::CMD_CLR: begin
            steady_in = steady_ff & ~cmd.mask;
            blink_in  = blink_ff & ~cmd.mask;
         end
         tlmc_pkg::CMD_NONE: begin
            steady_in = steady_ff;
         end
      endcase

      priority if (item.light_level > cfg.night_enter_level && !night_ff) begin
         night_in  = 1'b1;
         steady_in = tlmc_pkg::LAMP_NONE;
         blink_in  = tlmc_pkg::LAMP_YELLOW;
      end else if (item.light_level < cfg.day_enter_level && night_ff) begin
         night_in  = 1'b0;
         steady_in = tlmc_pkg::LAMP_NONE;
         blink_in  = tlmc_pkg::LAMP_NONE;
      end else begin
         night_in = night_ff;
      end

      if (elapsed >= {16'd0, cfg.blink_half_period_ms}) begin
         phase_in       = ~phase_ff;
         last_toggle_in = item.now_ms;
      end

      blink_in  = blink_in & ~press;
      steady_in = steady_in ^ press;

      if (item.motion) begin
         levels = {1'b0, 1'b0, phase_in};
      end else begin
         levels = (blink_in & {3{phase_in}}) | (~blink_in & steady_in);
      end

      buzz = blink_in[2] & ~blink_in[1] & ~blink_in[0] & ~item.motion & phase_in;

      changed        = ~reported_ff | (levels != last_levels_ff);
      last_levels_in = changed ? levels : last_levels_ff;
      reported_in    = reported_ff | changed;
      rsp_data_in    = {changed, buzz, levels[2], levels[1], levels[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steady_ff      <= '0;
         blink_ff       <= '0;
         phase_ff       <= 1'b0;
         night_ff       <= 1'b0;
         last_toggle_ff <= '0;
         prev_btn_ff    <= '1;
         last_levels_ff <= '0;
         reported_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            steady_ff      <= steady_in;
            blink_ff       <= blink_in;
            phase_ff       <= phase_in;
            night_ff       <= night_in;
            last_toggle_ff <= last_toggle_in;
            prev_btn_ff    <= item.btn;
            last_levels_ff <= last_levels_in;
            reported_ff    <= reported_in;
         end
         if (item_take) begin
            rsp_valid_ff <= item_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_red      = rsp_data_ff[0];
   assign rsp_led_yellow   = rsp_data_ff[1];
   assign rsp_led_green    = rsp_data_ff[2];
   assign rsp_buzzer_on    = rsp_data_ff[3];
   assign rsp_leds_changed = rsp_data_ff[4];

   `TLMC_ASSERT(a_buzz_green, clock, reset, rsp_valid_ff && rsp_data_ff[3] |-> rsp_data_ff[2])
   `TLMC_ASSERT(a_first_changed, clock, reset, fire && !reported_ff |=> rsp_data_ff[4])
   `TLMC_ASSERT(a_phase_hold, clock, reset, !fire |=> $stable(phase_ff) && $stable(steady_ff))
   `TLMC_ASSERT(a_reported_after, clock, reset, fire |=> reported_ff && rsp_valid_ff)

endmodule

### rtl/traffic_light_led_mode_controller.sv
// Top level of the traffic light lamp mode controller.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  func, light, buttons, motion, now_ms
//   rsp       out         rsp_valid / rsp_stall  led_red/yellow/green, buzzer_on, leds_changed
//   csr       in/out      psel/penable/pready    paddr, pwdata, prdata
//
// One request per cycle unless the result stalls, via the request and result registers.
// The lamp state updates in a single pass between the request and result registers.
// Synchronous reset clears all lamp flags and marks the buttons as held.
// A stalled result holds; the request register keeps accepting while the result is free.
`include "assert_macros.svh"
module traffic_light_led_mode_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [4:0]                  req_func,
   input  logic [11:0]                 req_light_level,
   input  logic                        req_btn_red_pressed,
   input  logic                        req_btn_yellow_pressed,
   input  logic                        req_btn_green_pressed,
   input  logic                        req_motion,
   input  logic [31:0]                 req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_led_red,
   output logic                        rsp_led_yellow,
   output logic                        rsp_led_green,
   output logic                        rsp_buzzer_on,
   output logic                        rsp_leds_changed,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tlmc_pkg::ADDR_W-1:0] paddr,
   input  logic [tlmc_pkg::DATA_W-1:0] pwdata,
   output logic [tlmc_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   tlmc_pkg::cfg_type  cfg;
   tlmc_pkg::item_type item_ff, item_in;
   logic               item_valid_ff;
   logic               item_take;
   logic               req_take;

   assign item_in.func        = req_func;
   assign item_in.light_level = req_light_level;
   assign item_in.btn         = {req_btn_green_pressed, req_btn_yellow_pressed,
                                 req_btn_red_pressed};
   assign item_in.motion      = req_motion;
   assign item_in.now_ms      = req_now_ms;

   assign req_take  = ~item_valid_ff | item_take;
   assign req_stall = ~req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_valid) begin
         item_ff <= item_in;
      end
   end

   tlmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlmc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item_valid       (item_valid_ff),
      .item             (item_ff),
      .item_take        (item_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_red      (rsp_led_red),
      .rsp_led_yellow   (rsp_led_yellow),
      .rsp_led_green    (rsp_led_green),
      .rsp_buzzer_on    (rsp_buzzer_on),
      .rsp_leds_changed (rsp_leds_changed)
   );

   `TLMC_ASSERT(a_stall_only_full, clock, reset, req_stall |-> item_valid_ff && rsp_valid)
   `TLMC_ASSERT(a_item_moves, clock, reset, item_valid_ff && item_take |=> rsp_valid)
   `TLMC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !item_valid_ff && !rsp_valid)

endmodule

### tb/tb_traffic_light_led_mode_controller.sv
// Self-checking testbench for the traffic light lamp controller with a lamp predictor.
`timescale 1ns / 1ps
module tb_traffic_light_led_mode_controller;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef enum logic [4:0] {
      FN_NONE, FN_ON_R, FN_ON_Y, FN_ON_G, FN_OFF_R, FN_OFF_Y, FN_OFF_G, FN_OFF_ALL,
      FN_BLK_R, FN_BLK_Y, FN_BLK_G, FN_BLK_ALL, FN_ON_RY, FN_ON_RG, FN_ON_YG, FN_ON_ALL,
      FN_OFF_RY, FN_OFF_RG, FN_OFF_YG, FN_BLK_RY, FN_BLK_RG, FN_BLK_YG
   } lamp_func_type;

   localparam logic [4:0] FN_CODE_MAX = 5'd31;

   typedef struct packed {
      logic [4:0]  func;
      logic [11:0] light;
      logic [2:0]  btn;      // bit0 red, bit1 yellow, bit2 green
      logic        motion;
      logic [31:0] now_ms;
   } lamp_req_type;

   typedef struct packed {
      logic red;
      logic yellow;
      logic green;
      logic buzzer;
      logic changed;
   } lamp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_func = '0;
   logic [11:0] req_light_level = '0;
   logic        req_btn_red_pressed = 1'b0;
   logic        req_btn_yellow_pressed = 1'b0;
   logic        req_btn_green_pressed = 1'b0;
   logic        req_motion = 1'b0;
   logic [31:0] req_now_ms = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_led_red, rsp_led_yellow, rsp_led_green, rsp_buzzer_on, rsp_leds_changed;

   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [tlmc_pkg::ADDR_W-1:0] paddr = '0;
   logic [tlmc_pkg::DATA_W-1:0] pwdata = '0;
   logic [tlmc_pkg::DATA_W-1:0] prdata;
   logic                        pready;

   traffic_light_led_mode_controller dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_light_level        (req_light_level),
      .req_btn_red_pressed    (req_btn_red_pressed),
      .req_btn_yellow_pressed (req_btn_yellow_pressed),
      .req_btn_green_pressed  (req_btn_green_pressed),
      .req_motion             (req_motion),
      .req_now_ms             (req_now_ms),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_led_red            (rsp_led_red),
      .rsp_led_yellow         (rsp_led_yellow),
      .rsp_led_green          (rsp_led_green),
      .rsp_buzzer_on          (rsp_buzzer_on),
      .rsp_leds_changed       (rsp_leds_changed),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // lamp controller shadow state
   tlmc_pkg::cfg_type lamp_cfg;
   logic [2:0]        steady_lamps, blink_lamps, prev_btn, last_levels;
   logic              blink_phase, night_mode, reported_once;
   logic [31:0]       last_toggle_ms;

   lamp_req_type pending_reqs[$];
   lamp_rsp_type expected_lamps[$];
   lamp_req_type held_req;
   lamp_rsp_type predicted, observed, wanted;

   int unsigned outstanding = 0;
   int unsigned requests_sent = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_left = 0;
   int unsigned stall_left = 0;
   logic        calm = 1'b0;
   logic [31:0] sim_ms;
   logic [2:0]  btn_hold;

   function automatic logic [2:0] func_lamps(input logic [4:0] f);
      logic [2:0] m;
      m[0] = f inside {FN_ON_R, FN_OFF_R, FN_BLK_R, FN_OFF_ALL, FN_BLK_ALL, FN_ON_RY,
                       FN_ON_RG, FN_ON_ALL, FN_OFF_RY, FN_OFF_RG, FN_BLK_RY, FN_BLK_RG};
      m[1] = f inside {FN_ON_Y, FN_OFF_Y, FN_BLK_Y, FN_OFF_ALL, FN_BLK_ALL, FN_ON_RY,
                       FN_ON_YG, FN_ON_ALL, FN_OFF_RY, FN_OFF_YG, FN_BLK_RY, FN_BLK_YG};
      m[2] = f inside {FN_ON_G, FN_OFF_G, FN_BLK_G, FN_OFF_ALL, FN_BLK_ALL, FN_ON_RG,
                       FN_ON_YG, FN_ON_ALL, FN_OFF_RG, FN_OFF_YG, FN_BLK_RG, FN_BLK_YG};
      return m;
   endfunction

   function automatic tlmc_pkg::cmd_kind_type func_kind(input logic [4:0] f);
      unique case (f)
         FN_ON_R, FN_ON_Y, FN_ON_G, FN_ON_RY, FN_ON_RG, FN_ON_YG, FN_ON_ALL:
            return tlmc_pkg::CMD_SET;
         FN_OFF_R, FN_OFF_Y, FN_OFF_G, FN_OFF_ALL, FN_OFF_RY, FN_OFF_RG, FN_OFF_YG:
            return tlmc_pkg::CMD_CLR;
         FN_BLK_R, FN_BLK_Y, FN_BLK_G, FN_BLK_ALL, FN_BLK_RY, FN_BLK_RG, FN_BLK_YG:
            return tlmc_pkg::CMD_BLK;
         default:
            return tlmc_pkg::CMD_NONE;
      endcase
   endfunction

   task automatic reset_lamp_model();
      lamp_cfg.night_enter_level    = tlmc_pkg::NIGHT_ENTER_RESET;
      lamp_cfg.day_enter_level      = tlmc_pkg::DAY_ENTER_RESET;
      lamp_cfg.blink_half_period_ms = tlmc_pkg::BLINK_HALF_RESET;
      steady_lamps   = '0;
      blink_lamps    = '0;
      blink_phase    = 1'b0;
      night_mode     = 1'b0;
      last_toggle_ms = '0;
      prev_btn       = 3'b111;
      last_levels    = '0;
      reported_once  = 1'b0;
   endtask

   task automatic predict_lamps(input lamp_req_type q, output lamp_rsp_type r);
      tlmc_pkg::cmd_kind_type kind;
      logic [2:0]             m;
      logic [2:0]             levels;
      logic [31:0]            elapsed;
      kind = func_kind(q.func);
      m = func_lamps(q.func);
      unique case (kind)
         tlmc_pkg::CMD_CLR: begin
            steady_lamps &= ~m;
            blink_lamps  &= ~m;
         end
         tlmc_pkg::CMD_SET: begin
            steady_lamps = m;
            blink_lamps  = '0;
         end
         tlmc_pkg::CMD_BLK: begin
            steady_lamps = '0;
            blink_lamps  = m;
         end
         default: ;
      endcase
      if (q.light > lamp_cfg.night_enter_level && !night_mode) begin
         night_mode   = 1'b1;
         steady_lamps = '0;
         blink_lamps  = tlmc_pkg::LAMP_YELLOW;
      end else if (q.light < lamp_cfg.day_enter_level && night_mode) begin
         night_mode   = 1'b0;
         steady_lamps = '0;
         blink_lamps  = '0;
      end
      elapsed = q.now_ms - last_toggle_ms;
      if (elapsed >= {16'd0, lamp_cfg.blink_half_period_ms}) begin
         blink_phase    = ~blink_phase;
         last_toggle_ms = q.now_ms;
      end
      for (int i = 0; i < 3; i++) begin
         if (q.btn[i] && !prev_btn[i]) begin
            blink_lamps[i]  = 1'b0;
            steady_lamps[i] = ~steady_lamps[i];
         end
      end
      prev_btn = q.btn;
      if (q.motion)
         levels = {2'b00, blink_phase};
      else
         for (int i = 0; i < 3; i++)
            levels[i] = blink_lamps[i] ? blink_phase : steady_lamps[i];
      r.red     = levels[0];
      r.yellow  = levels[1];
      r.green   = levels[2];
      r.buzzer  = (blink_lamps == 3'b100) && !q.motion && blink_phase;
      r.changed = !reported_once || levels != last_levels;
      if (r.changed) begin
         last_levels   = levels;
         reported_once = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_lamps(held_req, predicted);
            expected_lamps.push_back(predicted);
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (!calm && send_idle_left > 0) begin
               send_idle_left--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_idle_left = $urandom_range(0, 18);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               held_req = pending_reqs.pop_front();
               outstanding++;
               req_func               <= held_req.func;
               req_light_level        <= held_req.light;
               req_btn_red_pressed    <= held_req.btn[0];
               req_btn_yellow_pressed <= held_req.btn[1];
               req_btn_green_pressed  <= held_req.btn[2];
               req_motion             <= held_req.motion;
               req_now_ms             <= held_req.now_ms;
               req_valid              <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_led_red, rsp_led_yellow, rsp_led_green, rsp_buzzer_on,
                         rsp_leds_changed};
            if (expected_lamps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected lamp result: r%0b y%0b g%0b buz%0b chg%0b",
                           observed.red, observed.yellow, observed.green, observed.buzzer,
                           observed.changed);
            end else begin
               wanted = expected_lamps.pop_front();
               outstanding--;
               results_checked++;
               if (observed !== wanted) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("lamp result %0d (r y g buz chg): expected %05b, got %05b",
                              results_checked, wanted, observed);
               end
            end
         end
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      unique case (idx)
         tlmc_pkg::REG_NIGHT_ENTER: lamp_cfg.night_enter_level    = data[11:0];
         tlmc_pkg::REG_DAY_ENTER:   lamp_cfg.day_enter_level      = data[11:0];
         tlmc_pkg::REG_BLINK_HALF:  lamp_cfg.blink_half_period_ms = data[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int night, input int day, input int half);
      csr_write(tlmc_pkg::REG_NIGHT_ENTER, night);
      csr_write(tlmc_pkg::REG_DAY_ENTER, day);
      csr_write(tlmc_pkg::REG_BLINK_HALF, half);
      settings_used++;
   endtask

   task automatic drain_requests();
      do @(negedge clock); while (pending_reqs.size() != 0 || outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_request(input logic [4:0] f, input int light, input logic [2:0] b,
                               input logic mot, input logic [31:0] t);
      lamp_req_type q;
      q.func   = f;
      q.light  = 12'(light);
      q.btn    = b;
      q.motion = mot;
      q.now_ms = t;
      pending_reqs.push_back(q);
   endtask

   task automatic queue_random_requests(input int count);
      logic [4:0] f;
      int         light, pick, span;
      logic [31:0] t;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 8)
            f = FN_NONE;
         else if (pick < 17)
            f = 5'($urandom_range(FN_ON_R, FN_BLK_YG));
         else
            f = 5'($urandom_range(FN_BLK_YG + 1, FN_CODE_MAX));
         pick = $urandom_range(0, 3);
         if (pick < 2)
            light = int'(lamp_cfg.night_enter_level) + int'($urandom_range(0, 6)) - 3;
         else if (pick == 2)
            light = int'(lamp_cfg.day_enter_level) + int'($urandom_range(0, 6)) - 3;
         else
            light = $urandom_range(0, 4095);
         if (light < 0) light = 0;
         if (light > 4095) light = 4095;
         for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 3) == 0) btn_hold[i] = ~btn_hold[i];
         pick = $urandom_range(0, 39);
         span = int'(lamp_cfg.blink_half_period_ms) + int'(lamp_cfg.blink_half_period_ms) / 2 + 2;
         if (pick < 2) begin
            t = $urandom;
         end else if (pick == 2) begin
            t = 32'hFFFF_FFFF - $urandom_range(0, span);
         end else begin
            t = sim_ms + $urandom_range(0, span);
         end
         sim_ms = t;
         push_request(f, light, btn_hold, $urandom_range(0, 6) == 0, t);
      end
   endtask

   initial begin
      reset_lamp_model();
      btn_hold = '0;
      sim_ms = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // buttons held through reset must not count
      push_request(FN_NONE, 0, 3'b111, 1'b0, 32'd0);
      for (int c = FN_ON_R; c <= FN_BLK_YG; c++)
         push_request(5'(c), (c == FN_BLK_Y) ? 4095 : (c == FN_BLK_G) ? 0 : 1500,
                      {c == FN_BLK_RY, c == FN_ON_RY, c == FN_ON_G},
                      c == FN_OFF_Y, c * 250);
      push_request(FN_CODE_MAX, 1500, 3'b000, 1'b0, 32'hFFFF_FFFF);
      push_request(FN_NONE, 1500, 3'b000, 1'b0, 32'h0000_0100);
      queue_random_requests(80);
      drain_requests();

      apply_setting(0, 4095, 0);
      queue_random_requests(60);
      drain_requests();

      apply_setting(4095, 0, 65535);
      queue_random_requests(60);
      drain_requests();

      apply_setting(1500, 800, 1);
      queue_random_requests(80);
      drain_requests();

      apply_setting(2500, 2600, 250);
      queue_random_requests(80);
      drain_requests();

      apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 65535));
      queue_random_requests(40);
      drain_requests();
      queue_random_requests(40);
      drain_requests();

      apply_setting(2000, 1000, 100);
      calm = 1'b1;
      queue_random_requests(100);
      drain_requests();
      repeat (6) @(posedge clock);

      if (expected_lamps.size() != 0) mismatches += expected_lamps.size();
      $display("covered %0d requests and %0d lamp results under %0d threshold/blink settings",
               requests_sent, results_checked, settings_used + 1);
      $display("mismatched lamp results: %0d", mismatches);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
